// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the command frame validator RTL.
// Taken in by `include in the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also evaluated while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cfv_pkg.sv =====
// Shared types, codes and reset constants of the command frame validator.
// No dependencies.
package cfv_pkg;

   localparam int unsigned CSR_INDEX_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_IDENTITY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_READ     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_ERASE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_WRITE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_JUMP     = 3'd6;

   // Register reset values.
   localparam logic [7:0] RST_START_BYTE  = 8'd170;
   localparam logic [7:0] RST_MAX_PAYLOAD = 8'd255;
   localparam logic [7:0] RST_OP_IDENTITY = 8'd1;
   localparam logic [7:0] RST_OP_READ     = 8'd2;
   localparam logic [7:0] RST_OP_ERASE    = 8'd3;
   localparam logic [7:0] RST_OP_WRITE    = 8'd4;
   localparam logic [7:0] RST_OP_JUMP     = 8'd5;

   // Verdict codes.
   localparam logic [3:0] STATUS_OK        = 4'd0;
   localparam logic [3:0] STATUS_SHORT     = 4'd1;
   localparam logic [3:0] STATUS_START     = 4'd2;
   localparam logic [3:0] STATUS_LEN_MISM  = 4'd3;
   localparam logic [3:0] STATUS_TOO_LONG  = 4'd4;
   localparam logic [3:0] STATUS_CHECKSUM  = 4'd5;
   localparam logic [3:0] STATUS_EMPTY     = 4'd6;
   localparam logic [3:0] STATUS_UNKNOWN   = 4'd7;
   localparam logic [3:0] STATUS_CMD_LEN   = 4'd8;
   localparam logic [3:0] STATUS_UNALIGNED = 4'd9;

   // Command kinds.
   localparam logic [2:0] KIND_IDENTITY = 3'd0;
   localparam logic [2:0] KIND_READ     = 3'd1;
   localparam logic [2:0] KIND_ERASE    = 3'd2;
   localparam logic [2:0] KIND_WRITE    = 3'd3;
   localparam logic [2:0] KIND_JUMP     = 3'd4;
   localparam logic [2:0] KIND_NONE     = 3'd5;

   // Frame geometry.
   localparam logic [8:0] COUNT_MAX     = 9'd511;
   localparam logic [7:0] LEN_READ      = 8'd7;
   localparam logic [7:0] LEN_ERASE     = 8'd9;
   localparam logic [7:0] LEN_JUMP      = 8'd5;
   localparam logic [7:0] LEN_WRITE_MIN = 8'd6;
   localparam logic [7:0] WRITE_HDR_LEN = 8'd5;
   localparam logic [31:0] READ_SIZE_MAX = 32'd256;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_data_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [2:0]  command_kind;
      logic [31:0] target_address;
      logic [31:0] transfer_size;
      logic [7:0]  payload_length;
   } rsp_data_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] max_payload_len;
      logic [7:0] op_identity;
      logic [7:0] op_read;
      logic [7:0] op_erase;
      logic [7:0] op_write;
      logic [7:0] op_jump;
   } cfg_type;

   // Frame state as seen after the current byte has been folded in.
   typedef struct packed {
      logic [8:0]  byte_count;
      logic        start_mismatch;
      logic [7:0]  length_value;
      logic [7:0]  running_xor;
      logic [7:0]  command_value;
      logic [31:0] address_shift;
      logic [31:0] size_shift;
   } frame_type;

endpackage

// ===== rtl/cfv_csr.sv =====
// Configuration registers of the command frame validator.
// Depends on cfv_pkg.
module cfv_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_data,
   output cfv_pkg::cfg_type                 cfg
);

   cfv_pkg::cfg_type cfg_ff;
   cfv_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            cfv_pkg::CSR_START_BYTE:  cfg_in.start_byte      = csr_data;
            cfv_pkg::CSR_MAX_PAYLOAD: cfg_in.max_payload_len = csr_data;
            cfv_pkg::CSR_OP_IDENTITY: cfg_in.op_identity     = csr_data;
            cfv_pkg::CSR_OP_READ:     cfg_in.op_read         = csr_data;
            cfv_pkg::CSR_OP_ERASE:    cfg_in.op_erase        = csr_data;
            cfv_pkg::CSR_OP_WRITE:    cfg_in.op_write        = csr_data;
            cfv_pkg::CSR_OP_JUMP:     cfg_in.op_jump         = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte      <= cfv_pkg::RST_START_BYTE;
         cfg_ff.max_payload_len <= cfv_pkg::RST_MAX_PAYLOAD;
         cfg_ff.op_identity     <= cfv_pkg::RST_OP_IDENTITY;
         cfg_ff.op_read         <= cfv_pkg::RST_OP_READ;
         cfg_ff.op_erase        <= cfv_pkg::RST_OP_ERASE;
         cfg_ff.op_write        <= cfv_pkg::RST_OP_WRITE;
         cfg_ff.op_jump         <= cfv_pkg::RST_OP_JUMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/cfv_frame.sv =====
// Per-frame accumulator: byte counter, start check, length, running XOR and fields.
// Depends on cfv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfv_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic [7:0]           start_byte,
   output cfv_pkg::frame_type   frame_next
);

   cfv_pkg::frame_type frame_ff;
   cfv_pkg::frame_type frame_in;
   cfv_pkg::frame_type upd;
   logic [1:0]         addr_lane;
   logic [1:0]         size_lane;

   assign addr_lane = 2'(frame_ff.byte_count - 9'd3);
   assign size_lane = 2'(frame_ff.byte_count - 9'd7);

   always_comb begin
      upd = frame_ff;
      if (frame_ff.byte_count == 9'd0) begin
         upd.start_mismatch = (data_byte != start_byte);
      end else if (frame_ff.byte_count == 9'd1) begin
         upd.length_value = data_byte;
      end else if (!last_byte) begin
         // checksum byte itself is never folded into the XOR
         upd.running_xor = frame_ff.running_xor ^ data_byte;
         case (frame_ff.byte_count) inside
            9'd2: begin
               upd.command_value = data_byte;
            end
            [9'd3:9'd6]: begin
               upd.address_shift = frame_ff.address_shift
                                 | (32'(data_byte) << {addr_lane, 3'b000});
            end
            [9'd7:9'd10]: begin
               upd.size_shift = frame_ff.size_shift
                              | (32'(data_byte) << {size_lane, 3'b000});
            end
            default: begin
               upd.command_value = frame_ff.command_value;
            end
         endcase
      end
      if (frame_ff.byte_count != cfv_pkg::COUNT_MAX) begin
         upd.byte_count = frame_ff.byte_count + 9'd1;
      end
   end

   assign frame_next = upd;

   always_comb begin
      frame_in = frame_ff;
      if (advance) begin
         frame_in = last_byte ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else begin
         frame_ff <= frame_in;
      end
   end

   `ASSERT_CLK(a_clear_after_last, clock, reset, (advance && last_byte) |=> (frame_ff == '0), "frame state not cleared after last byte")
   `ASSERT_CLK(a_count_hold, clock, reset, !advance |=> $stable(frame_ff.byte_count), "byte count moved without a transfer")

endmodule

// ===== rtl/cfv_verdict.sv =====
// Verdict and field decode on the frame's last byte.
// Depends on cfv_pkg.
module cfv_verdict (
   input  cfv_pkg::frame_type   frame,
   input  logic [7:0]           checksum_byte,
   input  cfv_pkg::cfg_type     cfg,
   output cfv_pkg::rsp_data_type verdict
);

   logic [7:0]  len;
   logic [8:0]  len_plus3;
   logic [7:0]  write_data_len;
   logic [31:0] read_size;
   logic [2:0]  kind;
   logic [3:0]  status;
   logic [31:0] addr;
   logic [31:0] size;

   assign len            = frame.length_value;
   assign len_plus3      = {1'b0, len} + 9'd3;
   assign write_data_len = len - cfv_pkg::WRITE_HDR_LEN;
   assign read_size      = (frame.size_shift[15:0] > 16'(cfv_pkg::READ_SIZE_MAX))
                         ? cfv_pkg::READ_SIZE_MAX : {16'd0, frame.size_shift[15:0]};

   always_comb begin
      // first matching op register wins
      if (frame.command_value == cfg.op_identity)    kind = cfv_pkg::KIND_IDENTITY;
      else if (frame.command_value == cfg.op_read)   kind = cfv_pkg::KIND_READ;
      else if (frame.command_value == cfg.op_erase)  kind = cfv_pkg::KIND_ERASE;
      else if (frame.command_value == cfg.op_write)  kind = cfv_pkg::KIND_WRITE;
      else if (frame.command_value == cfg.op_jump)   kind = cfv_pkg::KIND_JUMP;
      else                                           kind = cfv_pkg::KIND_NONE;
   end

   always_comb begin
      status = cfv_pkg::STATUS_OK;
      addr   = '0;
      size   = '0;
      if (frame.byte_count < 9'd3) begin
         status = cfv_pkg::STATUS_SHORT;
      end else if (frame.start_mismatch) begin
         status = cfv_pkg::STATUS_START;
      end else if (frame.byte_count != len_plus3) begin
         status = cfv_pkg::STATUS_LEN_MISM;
      end else if (len > cfg.max_payload_len) begin
         status = cfv_pkg::STATUS_TOO_LONG;
      end else if (frame.running_xor != checksum_byte) begin
         status = cfv_pkg::STATUS_CHECKSUM;
      end else if (len == 8'd0) begin
         status = cfv_pkg::STATUS_EMPTY;
      end else begin
         case (kind)
            cfv_pkg::KIND_IDENTITY: begin
               status = cfv_pkg::STATUS_OK;
            end
            cfv_pkg::KIND_READ: begin
               if (len != cfv_pkg::LEN_READ) begin
                  status = cfv_pkg::STATUS_CMD_LEN;
               end else begin
                  addr = frame.address_shift;
                  size = read_size;
               end
            end
            cfv_pkg::KIND_ERASE: begin
               if (len != cfv_pkg::LEN_ERASE) begin
                  status = cfv_pkg::STATUS_CMD_LEN;
               end else begin
                  addr = frame.address_shift;
                  size = frame.size_shift;
               end
            end
            cfv_pkg::KIND_WRITE: begin
               if (len < cfv_pkg::LEN_WRITE_MIN) begin
                  status = cfv_pkg::STATUS_CMD_LEN;
               end else if (write_data_len[4:0] != 5'd0) begin
                  status = cfv_pkg::STATUS_UNALIGNED;
               end else begin
                  addr = frame.address_shift;
                  size = 32'(write_data_len);
               end
            end
            cfv_pkg::KIND_JUMP: begin
               if (len != cfv_pkg::LEN_JUMP) begin
                  status = cfv_pkg::STATUS_CMD_LEN;
               end else begin
                  addr = frame.address_shift;
               end
            end
            default: begin
               status = cfv_pkg::STATUS_UNKNOWN;
            end
         endcase
      end
   end

   always_comb begin
      verdict.status         = status;
      verdict.payload_length = len;
      verdict.target_address = (status == cfv_pkg::STATUS_OK) ? addr : 32'd0;
      verdict.transfer_size  = (status == cfv_pkg::STATUS_OK) ? size : 32'd0;
      if (status == cfv_pkg::STATUS_OK || status == cfv_pkg::STATUS_CMD_LEN
          || status == cfv_pkg::STATUS_UNALIGNED) begin
         verdict.command_kind = kind;
      end else begin
         verdict.command_kind = cfv_pkg::KIND_NONE;
      end
   end

endmodule

// ===== rtl/command_frame_validator_top.sv =====
// A transferred byte waits in the input register until it is folded into the frame
// state; a last byte's verdict is loaded into the result register, offered on rsp_.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two sides; only last bytes wait for the result register, and stall.
// Reset (synchronous, active high): registers take their reset values, the frame
// state clears and both stages empty; ready the cycle after reset drops.
`include "assert_macros.svh"

module command_frame_validator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cfv_pkg::req_data_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cfv_pkg::rsp_data_type            rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_data
);

   cfv_pkg::cfg_type      cfg;
   cfv_pkg::frame_type    frame_next;
   cfv_pkg::rsp_data_type verdict;

   logic                  s1_valid_ff, s1_valid_in;
   cfv_pkg::req_data_type s1_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   cfv_pkg::rsp_data_type rsp_data_ff;
   logic                  req_take;
   logic                  out_free;
   logic                  s1_adv;
   logic                  rsp_load;

   cfv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cfv_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_adv),
      .data_byte  (s1_data_ff.data_byte),
      .last_byte  (s1_data_ff.last_byte),
      .start_byte (cfg.start_byte),
      .frame_next (frame_next)
   );

   cfv_verdict u_verdict (
      .frame         (frame_next),
      .checksum_byte (s1_data_ff.data_byte),
      .cfg           (cfg),
      .verdict       (verdict)
   );

   // result slot frees up when empty or when its transfer happens this edge
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_data_ff.last_byte || out_free);
   assign rsp_load  = s1_adv && s1_data_ff.last_byte;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLK(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff) |-> $past(s1_adv && s1_data_ff.last_byte), "result appeared without a last byte")
   `ASSERT_CLK(a_stall_only_full, clock, reset, req_stall |-> s1_valid_ff, "input stalled with an empty input register")
   `ASSERT_CLK(a_fail_clears_fields, clock, reset, (rsp_valid_ff && rsp_data_ff.status != cfv_pkg::STATUS_OK) |-> (rsp_data_ff.target_address == 32'd0 && rsp_data_ff.transfer_size == 32'd0), "fields set on a failed frame")
   `ASSERT_CLK(a_ok_has_kind, clock, reset, (rsp_valid_ff && rsp_data_ff.status == cfv_pkg::STATUS_OK) |-> (rsp_data_ff.command_kind != cfv_pkg::KIND_NONE), "accepted frame without a command kind")

endmodule
